// ===== rtl/vertical_altitude_throttle_pid_macros.svh =====
// Assertion macros shared by the altitude / throttle controller RTL
`ifndef VERTICAL_ALTITUDE_THROTTLE_PID_MACROS_SVH
`define VERTICAL_ALTITUDE_THROTTLE_PID_MACROS_SVH

// same-cycle implication, reset masked
`define VATP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define VATP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vatp_pkg.sv =====
// Types, constants and helpers for the altitude / throttle controller
`timescale 1ns / 1ps
package vatp_pkg;

    localparam int unsigned FULL_THROTTLE        = 9600;
    localparam int unsigned ERROR_SUM_LIMIT      = 150;
    localparam logic signed [31:0] PITCH_DERIV_GAIN_Q16 = 32'sd0;

    localparam logic signed [31:0] ES_LIMIT_Q16 = 32'(ERROR_SUM_LIMIT * 65536);
    localparam logic signed [31:0] FULL_THR_Q   = 32'(FULL_THROTTLE);
    localparam logic [13:0]        FULL_THR_OUT = 14'(FULL_THROTTLE);

    localparam int unsigned NUM_REGS = 8;

    // register map indexes
    typedef enum logic [2:0] {
        REG_ALT_GAIN   = 3'd0,
        REG_MAX_CLIMB  = 3'd1,
        REG_CRUISE     = 3'd2,
        REG_CLIMB_INC  = 3'd3,
        REG_PGAIN      = 3'd4,
        REG_IGAIN      = 3'd5,
        REG_DGAIN      = 3'd6,
        REG_PITCH_GAIN = 3'd7
    } reg_idx_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [31:0] alt_gain;
        logic [30:0]        max_climb;
        logic [16:0]        cruise;
        logic signed [31:0] climb_inc;
        logic signed [31:0] pgain;
        logic signed [31:0] igain;
        logic signed [31:0] dgain;
        logic signed [31:0] pitch_gain;
    } cfg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_OUT
    } state_t;

    // micro-program steps, in execution order
    typedef enum logic [3:0] {
        OP_EALT,
        OP_MCLIMB,
        OP_ERR,
        OP_DIFF,
        OP_MIG,
        OP_MDG,
        OP_INNER,
        OP_MINC,
        OP_MPG,
        OP_CTRL,
        OP_MPDG,
        OP_PRE,
        OP_MPITCH,
        OP_POUT,
        OP_MTHR
    } step_t;

    // multiplier handshake
    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
        return {{2{x[31]}}, x};
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic is_mul(input step_t s);
        logic r;
        case (s) inside
            OP_MCLIMB, OP_MIG, OP_MDG, OP_MINC, OP_MPG,
            OP_MPDG, OP_MPITCH, OP_MTHR: r = 1'b1;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/vatp_mul.sv =====
// Bit-serial signed Q16.16 multiplier, truncating toward zero, saturating
`timescale 1ns / 1ps
`include "vertical_altitude_throttle_pid_macros.svh"
module vatp_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  vatp_pkg::mul_req_t  req,
    output logic                done,
    output logic signed [31:0]  result
);
    import vatp_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        mcand_reg, mcand_next;
    logic               neg_reg, neg_next;
    logic [32:0]        part_sum;
    logic [47:0]        mag_q;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;

    assign abs_a = req.a[31] ? (32'd0 - req.a) : req.a;
    assign abs_b = req.b[31] ? (32'd0 - req.b) : req.b;

    // one multiplier bit per cycle: add then shift right
    assign part_sum = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, mcand_reg} : 33'd0);

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        if (req.start && !busy_reg)
        begin
            busy_next  = 1'b1;
            cnt_next   = 5'd0;
            prod_next  = {32'd0, abs_b};
            mcand_next = abs_a;
            neg_next   = req.a[31] ^ req.b[31];
        end
        else if (busy_reg)
        begin
            prod_next = {part_sum, prod_reg[31:1]};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        neg_reg   <= neg_next;
    end

    // drop 16 fraction bits from the magnitude, restore sign, saturate
    assign mag_q = prod_reg[63:16];
    always_comb
    begin
        if (!neg_reg)
            result = (mag_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag_q[31:0];
        else
            result = (mag_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : (32'd0 - mag_q[31:0]);
    end

    assign done = done_reg;

    `VATP_ASSERT_NOW(a_no_restart, req.start, !busy_reg, "multiplier started while busy")
    `VATP_ASSERT_NEXT(a_done_idle, done_reg, !done_reg, "done longer than one cycle")
    `VATP_ASSERT_NOW(a_done_after_busy, done_reg, $past(busy_reg), "done without a run")

endmodule

// ===== rtl/vatp_cfg.sv =====
// APB register file for the controller gains and limits
`timescale 1ns / 1ps
module vatp_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output vatp_pkg::cfg_t     cfg
);
    import vatp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alt_gain   <= 32'sd0;
            cfg_reg.max_climb  <= 31'd131072;
            cfg_reg.cruise     <= 17'd29491;
            cfg_reg.climb_inc  <= 32'sd0;
            cfg_reg.pgain      <= 32'sd0;
            cfg_reg.igain      <= 32'sd0;
            cfg_reg.dgain      <= 32'sd0;
            cfg_reg.pitch_gain <= 32'sd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ALT_GAIN:   cfg_reg.alt_gain   <= pwdata;
                REG_MAX_CLIMB:  cfg_reg.max_climb  <= pwdata[30:0];
                REG_CRUISE:     cfg_reg.cruise     <= pwdata[16:0];
                REG_CLIMB_INC:  cfg_reg.climb_inc  <= pwdata;
                REG_PGAIN:      cfg_reg.pgain      <= pwdata;
                REG_IGAIN:      cfg_reg.igain      <= pwdata;
                REG_DGAIN:      cfg_reg.dgain      <= pwdata;
                REG_PITCH_GAIN: cfg_reg.pitch_gain <= pwdata;
                default:        ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_ALT_GAIN:   prdata = cfg_reg.alt_gain;
            REG_MAX_CLIMB:  prdata = {1'b0, cfg_reg.max_climb};
            REG_CRUISE:     prdata = {15'd0, cfg_reg.cruise};
            REG_CLIMB_INC:  prdata = cfg_reg.climb_inc;
            REG_PGAIN:      prdata = cfg_reg.pgain;
            REG_IGAIN:      prdata = cfg_reg.igain;
            REG_DGAIN:      prdata = cfg_reg.dgain;
            REG_PITCH_GAIN: prdata = cfg_reg.pitch_gain;
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/vertical_altitude_throttle_pid.sv =====
// Top level: cascaded altitude P / climb-rate PID throttle controller
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | tvalid/tready              | tdata[127:0]: target, measured, vspeed, pitch
//  m_axis    | out | tvalid/tready              | tdata[79:0]: throttle, pitch_out, climb_target
//  apb       | cfg | psel/penable/pwrite/pready | paddr[4:0], pwdata/prdata[31:0]
//
// A request runs eight products through one bit-serial 32x32 multiplier
// (each: start, one shift-add per multiplier bit, done) and seven add
// steps, between the accept in the idle state and the output state.
// A new request is taken once the previous one leaves the sequencer; the
// result register holds one finished result while the next is computed.
// Reset clears the configuration to defaults and the loop state to zero.
`timescale 1ns / 1ps
`include "vertical_altitude_throttle_pid_macros.svh"
module vertical_altitude_throttle_pid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // altitude_target[31:0], altitude_measured[63:32], vertical_speed[95:64], pitch_in[127:96]
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // throttle_command[13:0], pitch_out[45:14], climb_target[77:46], zero[79:78]
    output logic [79:0]   m_axis_tdata
);
    import vatp_pkg::*;

    cfg_t               cfg;
    mul_req_t           mreq;
    logic               mul_start;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               mdone;
    logic signed [31:0] mres;

    state_t state_reg, state_next;
    step_t  step_reg;

    logic signed [31:0] tgt_reg, meas_reg, vz_reg, pin_reg;
    logic signed [31:0] ealt_reg, climb_reg, err_reg, d_reg;
    logic signed [31:0] t1_reg, t2_reg, inner_reg, ctrl_reg, xpre_reg, pout_reg, thr_reg;
    logic signed [31:0] prev_reg, es_reg;
    logic               mval_reg;
    logic [79:0]        mdata_reg;

    logic               in_acc;
    logic               out_free;
    logic               last_step;
    logic signed [33:0] lim34;
    logic signed [33:0] es_sum;
    logic signed [31:0] es_clamped;
    logic signed [31:0] climb_new;
    logic [13:0]        thr_out;

    vatp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vatp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .done   (mdone),
        .result (mres)
    );

    assign mreq = '{start: mul_start, a: mul_a, b: mul_b};

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !mval_reg || m_axis_tready;
    assign last_step = (step_reg == OP_MTHR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_EXEC;
            ST_EXEC: if (is_mul(step_reg)) state_next = ST_WAIT;
            ST_WAIT: if (mdone) state_next = last_step ? ST_OUT : ST_EXEC;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: mul_start = is_mul(step_reg);
            ST_WAIT: ;
            ST_OUT:  ;
            default: ;
        endcase
    end

    // multiplier operands per step
    always_comb
    begin
        case (step_reg)
            OP_MCLIMB: begin mul_a = cfg.alt_gain;  mul_b = ealt_reg;             end
            OP_MIG:    begin mul_a = cfg.igain;     mul_b = es_reg;               end
            OP_MDG:    begin mul_a = cfg.dgain;     mul_b = d_reg;                end
            OP_MINC:   begin mul_a = cfg.climb_inc; mul_b = climb_reg;            end
            OP_MPG:    begin mul_a = cfg.pgain;     mul_b = inner_reg;            end
            OP_MPDG:   begin mul_a = d_reg;         mul_b = PITCH_DERIV_GAIN_Q16; end
            OP_MPITCH: begin mul_a = xpre_reg;      mul_b = cfg.pitch_gain;       end
            OP_MTHR:   begin mul_a = ctrl_reg;      mul_b = FULL_THR_Q;           end
            default:   begin mul_a = 32'sd0;        mul_b = 32'sd0;               end
        endcase
    end

    // climb clamp to +/- max climb rate
    assign lim34 = {3'b000, cfg.max_climb};
    always_comb
    begin
        if (sx34(mres) > lim34)
            climb_new = lim34[31:0];
        else if (sx34(mres) < -lim34)
            climb_new = 32'(-lim34);
        else
            climb_new = mres;
    end

    // error sum update with clamp
    assign es_sum = sx34(es_reg) + sx34(err_reg);
    always_comb
    begin
        if (es_sum > sx34(ES_LIMIT_Q16))
            es_clamped = ES_LIMIT_Q16;
        else if (es_sum < -sx34(ES_LIMIT_Q16))
            es_clamped = -ES_LIMIT_Q16;
        else
            es_clamped = es_sum[31:0];
    end

    // throttle clamp to 0..full scale
    always_comb
    begin
        if (thr_reg[31])
            thr_out = 14'd0;
        else if (thr_reg > FULL_THR_Q)
            thr_out = FULL_THR_OUT;
        else
            thr_out = thr_reg[13:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= OP_EALT;
            mval_reg  <= 1'b0;
            prev_reg  <= 32'sd0;
            es_reg    <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
                step_reg <= OP_EALT;
            else if ((state_reg == ST_EXEC && !is_mul(step_reg)) ||
                     (state_reg == ST_WAIT && mdone && !last_step))
                step_reg <= step_t'(step_reg + 4'd1);
            if (state_reg == ST_OUT && out_free)
                mval_reg <= 1'b1;
            else if (m_axis_tready)
                mval_reg <= 1'b0;
            if (state_reg == ST_EXEC && step_reg == OP_POUT)
            begin
                prev_reg <= err_reg;
                es_reg   <= es_clamped;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tgt_reg  <= s_axis_tdata[31:0];
            meas_reg <= s_axis_tdata[63:32];
            vz_reg   <= s_axis_tdata[95:64];
            pin_reg  <= s_axis_tdata[127:96];
        end
        if (state_reg == ST_EXEC)
        begin
            case (step_reg)
                OP_EALT:  ealt_reg  <= sat32(sx34(tgt_reg) - sx34(meas_reg));
                OP_ERR:   err_reg   <= sat32(sx34(vz_reg) - sx34(climb_reg));
                OP_DIFF:  d_reg     <= sat32(sx34(err_reg) - sx34(prev_reg));
                OP_INNER: inner_reg <= sat32(sx34(err_reg) + sx34(t1_reg) + sx34(t2_reg));
                OP_CTRL:  ctrl_reg  <= sat32(sx34({15'd0, cfg.cruise}) + sx34(t1_reg)
                                             - sx34(t2_reg));
                OP_PRE:   xpre_reg  <= sat32(sx34(climb_reg) + sx34(t1_reg));
                OP_POUT:  pout_reg  <= sat32(sx34(pin_reg) + sx34(t2_reg));
                default:  ;
            endcase
        end
        if (state_reg == ST_WAIT && mdone)
        begin
            case (step_reg) inside
                OP_MCLIMB:                  climb_reg <= climb_new;
                OP_MIG, OP_MINC, OP_MPDG:   t1_reg    <= mres;
                OP_MDG, OP_MPG, OP_MPITCH:  t2_reg    <= mres;
                OP_MTHR:                    thr_reg   <= mres;
                default:                    ;
            endcase
        end
        if (state_reg == ST_OUT && out_free)
            mdata_reg <= {2'b00, climb_reg, pout_reg, thr_out};
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;

    `VATP_ASSERT_NOW(a_busy_no_accept, state_reg != ST_IDLE, !s_axis_tready,
        "request taken while busy")
    `VATP_ASSERT_NOW(a_es_bound, 1'b1,
        (es_reg <= ES_LIMIT_Q16) && (es_reg >= -ES_LIMIT_Q16), "error sum out of range")
    `VATP_ASSERT_NOW(a_thr_range, mval_reg, m_axis_tdata[13:0] <= FULL_THR_OUT,
        "throttle beyond full scale")
    `VATP_ASSERT_NEXT(a_out_load, state_reg == ST_OUT && out_free, m_axis_tvalid,
        "result not presented")

endmodule

// ===== tb/vertical_altitude_throttle_pid_tb.sv =====
// Testbench for the altitude / throttle controller: queued stimulus, own predictor, stream check
`timescale 1ns / 1ps
module vertical_altitude_throttle_pid_tb;
    import vatp_pkg::*;

    localparam int SETTLE_CYCLES = 400;

    logic          clk;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [79:0]   m_axis_tdata;

    vertical_altitude_throttle_pid dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor copy of registers and loop state
    logic signed [31:0] m_alt_gain, m_incr, m_pg, m_ig, m_dg, m_pitch_gain;
    logic [30:0]        m_max_climb;
    logic [16:0]        m_cruise;
    longint             m_prev_err, m_err_sum;

    logic [127:0] pending_requests[$];
    logic [79:0]  expected_results[$];
    int           errors;
    int           send_idle_pct;
    int           recv_stall_pct;

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 product truncated toward zero, then saturated
    function automatic longint qprod(input longint a, input longint b);
        return clip32((a * b) / 65536);
    endfunction

    function automatic longint clip_abs(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic logic [79:0] control_tick(input logic [127:0] req);
        longint tgt, meas, vz, pit, e_alt, climb, err, d, inner, ctrl, pre, pout, thr;
        tgt = longint'($signed(req[31:0]));
        meas = longint'($signed(req[63:32]));
        vz = longint'($signed(req[95:64]));
        pit = longint'($signed(req[127:96]));
        e_alt = clip32(tgt - meas);
        climb = clip_abs(qprod(m_alt_gain, e_alt), longint'(m_max_climb));
        err = clip32(vz - climb);
        d = clip32(err - m_prev_err);
        inner = clip32(err + qprod(m_ig, m_err_sum) + qprod(m_dg, d));
        ctrl = clip32(longint'(m_cruise) + qprod(m_incr, climb) - qprod(m_pg, inner));
        pre = qprod(clip32(climb + qprod(d, longint'(PITCH_DERIV_GAIN_Q16))), m_pitch_gain);
        pout = clip32(pit + pre);
        m_prev_err = err;
        m_err_sum = clip_abs(clip32(m_err_sum + err), longint'(ERROR_SUM_LIMIT) * 65536);
        thr = (ctrl * longint'(FULL_THROTTLE)) / 65536;
        if (thr < 0) thr = 0;
        if (thr > longint'(FULL_THROTTLE)) thr = longint'(FULL_THROTTLE);
        return {2'b00, climb[31:0], pout[31:0], thr[13:0]};
    endfunction

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            3: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_requests[0];
                expected_results.push_back(control_tick(pending_requests.pop_front()));
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor and ready stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    logic [79:0] exp_r;
                    exp_r = expected_results.pop_front();
                    if (exp_r[13:0] !== m_axis_tdata[13:0])
                    begin
                        errors++;
                        $display("%0t: throttle_command expected %0d actual %0d", $time,
                                 exp_r[13:0], m_axis_tdata[13:0]);
                    end
                    if (exp_r[45:14] !== m_axis_tdata[45:14])
                    begin
                        errors++;
                        $display("%0t: pitch_out expected %h actual %h", $time,
                                 exp_r[45:14], m_axis_tdata[45:14]);
                    end
                    if (exp_r[79:46] !== m_axis_tdata[79:46])
                    begin
                        errors++;
                        $display("%0t: climb_target expected %h actual %h", $time,
                                 exp_r[79:46], m_axis_tdata[79:46]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // register write; also updates the predictor's copy
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ALT_GAIN:   m_alt_gain = value;
            REG_MAX_CLIMB:  m_max_climb = value[30:0];
            REG_CRUISE:     m_cruise = value[16:0];
            REG_CLIMB_INC:  m_incr = value;
            REG_PGAIN:      m_pg = value;
            REG_IGAIN:      m_ig = value;
            REG_DGAIN:      m_dg = value;
            default:        m_pitch_gain = value;
        endcase
    endtask

    task automatic drain;
        while (pending_requests.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            pending_requests.push_back({rand_word($urandom_range(0, 6)),
                                        rand_word($urandom_range(0, 6)),
                                        rand_word($urandom_range(0, 6)),
                                        rand_word($urandom_range(0, 6))});
    endtask

    task automatic set_gains(input int kind);
        logic [31:0] climb_word;
        write_reg(REG_ALT_GAIN, rand_word(kind));
        climb_word = rand_word(kind);
        write_reg(REG_MAX_CLIMB, {1'b0, climb_word[30:0]});
        write_reg(REG_CRUISE, 32'($urandom_range(0, 131071)));
        write_reg(REG_CLIMB_INC, rand_word(kind));
        write_reg(REG_PGAIN, rand_word(kind));
        write_reg(REG_IGAIN, rand_word(kind));
        write_reg(REG_DGAIN, rand_word(kind));
        write_reg(REG_PITCH_GAIN, rand_word(kind));
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_alt_gain = 0; m_max_climb = 31'd131072; m_cruise = 17'd29491;
        m_incr = 0; m_pg = 0; m_ig = 0; m_dg = 0; m_pitch_gain = 0;
        m_prev_err = 0; m_err_sum = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults: cruise only, extremes of the inputs
        pending_requests.push_back({32'h0, 32'h0, 32'h0, 32'h0});
        pending_requests.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        pending_requests.push_back({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();

        // unity-ish gains: clamped climb, error sum saturation, intermediate overflow
        write_reg(REG_ALT_GAIN, 32'h0001_0000);
        write_reg(REG_MAX_CLIMB, 32'h0003_0000);
        write_reg(REG_CRUISE, 32'h0001_0000);
        write_reg(REG_CLIMB_INC, 32'h0000_8000);
        write_reg(REG_PGAIN, 32'h0000_4000);
        write_reg(REG_IGAIN, 32'h0000_1000);
        write_reg(REG_DGAIN, 32'h0000_2000);
        write_reg(REG_PITCH_GAIN, 32'h0000_8000);
        repeat (6) pending_requests.push_back({32'h0, 32'h0064_0000, 32'h0, 32'h0});
        repeat (6) pending_requests.push_back({32'h0, 32'h9C00_0000, 32'h0, 32'h0});
        pending_requests.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        pending_requests.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();

        // extreme register values, cruise above one
        write_reg(REG_ALT_GAIN, 32'h8000_0000);
        write_reg(REG_MAX_CLIMB, 32'h7FFF_FFFF);
        write_reg(REG_CRUISE, 32'h0001_FFFF);
        write_reg(REG_CLIMB_INC, 32'h7FFF_FFFF);
        write_reg(REG_PGAIN, 32'h8000_0000);
        write_reg(REG_IGAIN, 32'h7FFF_FFFF);
        write_reg(REG_DGAIN, 32'h8000_0000);
        write_reg(REG_PITCH_GAIN, 32'h7FFF_FFFF);
        push_random(6);
        drain();

        // random phases with varied idling
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            set_gains($urandom_range(2, 6));
            push_random(62);
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #15ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
